@@ hw/rtl/srl_pkg.sv @@
// Shared types, constants and the hex digit decoder of the S-record loader.
package srl_pkg;

  localparam logic [7:0] CharS     = 8'h53;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7a;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CaseDelta = 8'h20;
  localparam logic [7:0] HexTen    = 8'h0a;
  localparam logic [7:0] HdrBytes  = 8'h03;
  localparam logic [15:0] EndAddrReset = 16'hffff;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_TYPE  = 4'd1,
    PH_SKIP  = 4'd2,
    PH_CNT_H = 4'd3,
    PH_CNT_L = 4'd4,
    PH_AHI_H = 4'd5,
    PH_AHI_L = 4'd6,
    PH_ALO_H = 4'd7,
    PH_ALO_L = 4'd8,
    PH_DAT_H = 4'd9,
    PH_DAT_L = 4'd10,
    PH_CK_H  = 4'd11,
    PH_CK_L  = 4'd12,
    PH_TAIL  = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_SEG   = 2'd1,
    KIND_CKERR = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  data;
  } result_t;

  // Letters are folded to upper case; anything outside A to F decodes as
  // its offset from the zero character, modulo 256.
  function automatic logic [7:0] digit_value(input logic [7:0] ch);
    logic [7:0] u;
    logic [7:0] v;
    u = ch;
    if (u >= CharLowA && u <= CharLowZ) begin
      u = u - CaseDelta;
    end
    if (u >= CharUpA && u <= CharUpF) begin
      v = u - CharUpA + HexTen;
    end else begin
      v = u - CharZero;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/srl_core.sv @@
// Record parser state and the per-character update of the S-record loader.
module srl_core import srl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  logic       eoi_i,
  output result_t    result_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  logic [7:0]  rem_q, rem_d;
  logic [15:0] rec_addr_q, rec_addr_d;
  logic [15:0] prev_end_q, prev_end_d;
  logic [7:0]  sum_q, sum_d;
  logic        failed_q, failed_d;

  logic [7:0]  digit;
  logic [7:0]  byte_val;
  logic [15:0] lo_addr;
  logic [15:0] next_addr;
  logic [7:0]  rem_dec;

  assign digit     = digit_value(char_i);
  assign byte_val  = {nib_q, 4'b0000} + digit;
  assign lo_addr   = {rec_addr_q[15:8], byte_val};
  assign next_addr = rec_addr_q + 16'd1;
  assign rem_dec   = rem_q - 8'd1;

  always_comb begin
    phase_d    = phase_q;
    nib_d      = nib_q;
    rem_d      = rem_q;
    rec_addr_d = rec_addr_q;
    prev_end_d = prev_end_q;
    sum_d      = sum_q;
    failed_d   = failed_q;
    result_o   = '0;
    if (failed_q) begin
      result_o = '0;
    end else if (eoi_i) begin
      phase_d       = PH_HUNT;
      nib_d         = '0;
      rem_d         = '0;
      rec_addr_d    = '0;
      prev_end_d    = EndAddrReset;
      sum_d         = '0;
      result_o.valid = 1'b1;
      result_o.kind  = KIND_DONE;
    end else begin
      unique case (phase_q)
        PH_HUNT: begin
          if (char_i == CharS) begin
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          phase_d = (char_i == CharZero || char_i == CharNine) ? PH_SKIP : PH_CNT_H;
        end
        PH_SKIP: begin
          if (char_i == CharLf) begin
            phase_d = PH_HUNT;
          end
        end
        PH_TAIL: begin
          phase_d = PH_HUNT;
        end
        PH_CNT_H, PH_AHI_H, PH_ALO_H, PH_DAT_H, PH_CK_H: begin
          nib_d   = digit[3:0];
          phase_d = phase_e'(phase_q + 4'd1);
        end
        PH_CNT_L: begin
          sum_d   = byte_val;
          rem_d   = (byte_val > HdrBytes) ? byte_val - HdrBytes : '0;
          phase_d = PH_AHI_H;
        end
        PH_AHI_L: begin
          sum_d      = sum_q + byte_val;
          rec_addr_d = {byte_val, 8'h00};
          phase_d    = PH_ALO_H;
        end
        PH_ALO_L: begin
          sum_d      = sum_q + byte_val;
          rec_addr_d = lo_addr;
          if (rem_q != '0) begin
            phase_d = PH_DAT_H;
          end else begin
            prev_end_d = lo_addr;
            phase_d    = PH_CK_H;
          end
          if (lo_addr != prev_end_q) begin
            result_o.valid   = 1'b1;
            result_o.kind    = KIND_SEG;
            result_o.address = lo_addr;
          end
        end
        PH_DAT_L: begin
          sum_d      = sum_q + byte_val;
          rec_addr_d = next_addr;
          rem_d      = rem_dec;
          if (rem_dec == '0) begin
            prev_end_d = next_addr;
            phase_d    = PH_CK_H;
          end else begin
            phase_d = PH_DAT_H;
          end
          result_o.valid   = 1'b1;
          result_o.kind    = KIND_WRITE;
          result_o.address = rec_addr_q;
          result_o.data    = byte_val;
        end
        PH_CK_L: begin
          if (~sum_q != byte_val) begin
            failed_d       = 1'b1;
            phase_d        = PH_HUNT;
            result_o.valid = 1'b1;
            result_o.kind  = KIND_CKERR;
          end else begin
            phase_d = PH_TAIL;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      nib_q      <= '0;
      rem_q      <= '0;
      rec_addr_q <= '0;
      prev_end_q <= EndAddrReset;
      sum_q      <= '0;
      failed_q   <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      nib_q      <= nib_d;
      rem_q      <= rem_d;
      rec_addr_q <= rec_addr_d;
      prev_end_q <= prev_end_d;
      sum_q      <= sum_d;
      failed_q   <= failed_d;
    end
  end

  a_lock_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> failed_q)
    else $error("Lock after a checksum error was released.");

  a_lock_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> !result_o.valid)
    else $error("Result produced while locked.");

  a_ckerr_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.valid && result_o.kind == KIND_CKERR |=> failed_q)
    else $error("Checksum error did not lock the parser.");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.kind != KIND_WRITE |-> result_o.data == '0)
    else $error("Non-write result carries data.");

endmodule

@@ hw/rtl/srecord_s1_loader.sv @@
// Top level of the S1 S-record loader: input register, parser and result register.
//
// Characters arrive on the input channel (character_i, end_of_input_i) under
// in_valid_i / in_stall_o; results leave on the output channel (kind_o,
// address_o, data_o) under out_valid_o / out_stall_i. A transaction completes
// at a rising edge where valid is high and stall is low.
// Each character yields zero or one result: a memory write, a segment start,
// a checksum error or, for an end-of-input transaction, load complete.
// A character taken into the input register is parsed from there; its result
// is captured when the result register is empty or the receiver is not stalling.
// Throughput is one character per cycle unless the receiver stalls; the parser
// state update is one combinational step between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall_o rises only once both are occupied, so no transaction is
// lost. After a checksum error the parser ignores everything until reset.
// Reset is asynchronous and active low; it empties both registers and puts
// the parser back to hunting for the start of a record.
module srecord_s1_loader import srl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] address_o,
  output logic [7:0]  data_o
);

  logic        in_vld_q;
  logic [7:0]  char_q;
  logic        eoi_q;
  logic        out_vld_q;
  kind_e       kind_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic        advance;
  logic        step;
  result_t     res;

  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign step       = in_vld_q && advance;

  srl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (char_q),
    .eoi_i    (eoi_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= step && res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= character_i;
      eoi_q  <= end_of_input_i;
    end
    if (step && res.valid) begin
      kind_q <= res.kind;
      addr_q <= res.address;
      data_q <= res.data;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign address_o   = addr_q;
  assign data_o      = data_q;

endmodule
